@@ hdl/rrss_pkg.sv @@
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared sizes, codes and controller/datapath interface types of the
// round-robin sleep scheduler.
// ----------------------------------------------------------------------------
package rrss_pkg;

    localparam int MAX_TASKS = 8;
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int TICK_W    = 32;
    localparam int IDX_W     = 3;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_DELAY = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_IDLE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DEC,
        S_SEARCH,
        S_FINISH
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic dec_step;
        logic search_init;
        logic search_step;
        logic load_out;
    } rrss_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        command_t cmd;
        logic     active;
        logic     dec_last;
        logic     search_end;
    } rrss_stat_t;

endpackage

@@ hdl/round_robin_sleep_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// round_robin_sleep_scheduler_unit
// Hardware task scheduler with per-slot sleep counters and round-robin
// selection of the next ready task.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------
//  input   | in_valid / in_ready  | command, sleep_ticks
//  output  | out_valid / out_ready| task_index, switch_request, status
//
// One command is in work at a time; in_ready is high only while idle. Add,
// start and ignored commands run execute and finish; a tick on a running
// table also sweeps the counters of its N occupied slots, then searches them
// round-robin; a delay only searches. A result not taken waits in the output
// register; the next command then stalls in its final state with in_ready low.
// Reset clears the sleep counters, the task table and out_valid.
// ----------------------------------------------------------------------------
module round_robin_sleep_scheduler_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    command,
    input  logic [rrss_pkg::TICK_W-1:0]   sleep_ticks,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rrss_pkg::IDX_W-1:0]    task_index,
    output logic                          switch_request,
    output logic [1:0]                    status
);

    rrss_pkg::rrss_cmd_t  dp_cmd;
    rrss_pkg::rrss_stat_t dp_stat;

    rrss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    rrss_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .command        (command),
        .sleep_ticks    (sleep_ticks),
        .cmd            (dp_cmd),
        .stat           (dp_stat),
        .task_index     (task_index),
        .switch_request (switch_request),
        .status         (status)
    );

endmodule

@@ hdl/rrss_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrss_ctrl
// Sequencer of the scheduler: accepts a command, steps the datapath through
// execute, counter sweep and round-robin search, and owns the output valid.
// ----------------------------------------------------------------------------
module rrss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rrss_pkg::rrss_stat_t stat,
    output rrss_pkg::rrss_cmd_t  cmd
);

    rrss_pkg::state_t state_reg;
    rrss_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrss_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            rrss_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = rrss_pkg::S_EXEC;
                end
            end
            rrss_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.active && stat.cmd == rrss_pkg::CMD_TICK)
                begin
                    state_next = rrss_pkg::S_DEC;
                end
                else if (stat.active && stat.cmd == rrss_pkg::CMD_DELAY)
                begin
                    state_next = rrss_pkg::S_SEARCH;
                end
                else
                begin
                    state_next = rrss_pkg::S_FINISH;
                end
            end
            rrss_pkg::S_DEC:
            begin
                cmd.dec_step = 1'b1;
                if (stat.dec_last)
                begin
                    cmd.search_init = 1'b1;
                    state_next      = rrss_pkg::S_SEARCH;
                end
            end
            rrss_pkg::S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (stat.search_end)
                begin
                    state_next = rrss_pkg::S_FINISH;
                end
            end
            rrss_pkg::S_FINISH:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = rrss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rrss_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hdl/rrss_dp.sv @@
// ----------------------------------------------------------------------------
// rrss_dp
// Datapath of the scheduler: sleep counters, task table state, a shared
// decrementer swept over the slots, a one-slot-per-cycle round-robin search
// and the output register.
// ----------------------------------------------------------------------------
module rrss_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    command,
    input  logic [rrss_pkg::TICK_W-1:0]   sleep_ticks,
    input  rrss_pkg::rrss_cmd_t           cmd,
    output rrss_pkg::rrss_stat_t          stat,
    output logic [rrss_pkg::IDX_W-1:0]    task_index,
    output logic                          switch_request,
    output logic [1:0]                    status
);

    logic [rrss_pkg::TICK_W-1:0] counter_reg [rrss_pkg::MAX_TASKS];
    logic [rrss_pkg::CNT_W-1:0]  count_reg;
    logic [rrss_pkg::SLOT_W-1:0] current_reg;
    logic                        running_reg;

    rrss_pkg::command_t          cmd_reg;
    logic [rrss_pkg::TICK_W-1:0] ticks_reg;
    logic [rrss_pkg::SLOT_W-1:0] idx_reg;
    logic [rrss_pkg::SLOT_W-1:0] cand_reg;
    logic [rrss_pkg::SLOT_W-1:0] base_reg;
    logic [rrss_pkg::CNT_W-1:0]  k_reg;

    logic [rrss_pkg::IDX_W-1:0]  res_index_reg;
    logic                        res_sw_reg;
    rrss_pkg::status_t           res_status_reg;
    logic [rrss_pkg::IDX_W-1:0]  task_index_reg;
    logic                        switch_request_reg;
    rrss_pkg::status_t           status_reg;

    logic                        active;
    logic                        full;
    logic                        cur_valid;
    logic [rrss_pkg::SLOT_W-1:0] base_slot;
    logic [rrss_pkg::SLOT_W-1:0] cand_next;
    logic [rrss_pkg::TICK_W-1:0] dec_value;
    logic [rrss_pkg::TICK_W-1:0] cand_value;
    logic                        search_exhausted;
    logic                        search_hit;

    assign active    = running_reg && (count_reg != '0);
    assign full      = (count_reg >= rrss_pkg::CNT_W'(rrss_pkg::MAX_TASKS));
    assign cur_valid = (rrss_pkg::CNT_W'(current_reg) < count_reg);
    assign base_slot = cur_valid ? current_reg : '0;

    assign dec_value  = counter_reg[idx_reg];
    assign cand_value = counter_reg[cand_reg];

    // Round-robin successor of the candidate among the occupied slots.
    assign cand_next = ((rrss_pkg::CNT_W'(cand_reg) + rrss_pkg::CNT_W'(1)) == count_reg)
                       ? '0 : cand_reg + rrss_pkg::SLOT_W'(1);

    assign search_exhausted = (k_reg >= count_reg);
    assign search_hit       = !search_exhausted && (cand_value == '0);

    assign stat.cmd        = cmd_reg;
    assign stat.active     = active;
    assign stat.dec_last   = ((rrss_pkg::CNT_W'(idx_reg) + rrss_pkg::CNT_W'(1)) >= count_reg);
    assign stat.search_end = search_exhausted || search_hit;

    // Scheduler state with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rrss_pkg::MAX_TASKS; i++)
            begin
                counter_reg[i] <= '0;
            end
            count_reg   <= '0;
            current_reg <= '0;
            running_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                case (cmd_reg)
                    rrss_pkg::CMD_ADD:
                    begin
                        if (!full)
                        begin
                            counter_reg[count_reg[rrss_pkg::SLOT_W-1:0]] <= '0;
                            count_reg <= count_reg + rrss_pkg::CNT_W'(1);
                        end
                    end
                    rrss_pkg::CMD_START:
                    begin
                        if (count_reg != '0)
                        begin
                            current_reg <= '0;
                            running_reg <= 1'b1;
                        end
                    end
                    rrss_pkg::CMD_DELAY:
                    begin
                        if (active && cur_valid)
                        begin
                            counter_reg[current_reg] <= ticks_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.dec_step && dec_value != '0)
            begin
                counter_reg[idx_reg] <= dec_value - rrss_pkg::TICK_W'(1);
            end
            if (cmd.search_step)
            begin
                if (search_exhausted)
                begin
                    current_reg <= base_reg;
                end
                else if (search_hit)
                begin
                    current_reg <= cand_reg;
                end
            end
        end
    end

    // Per-command working registers and the result.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= rrss_pkg::command_t'(command);
            ticks_reg <= sleep_ticks;
            idx_reg   <= '0;
        end
        if (cmd.dec_step)
        begin
            idx_reg <= idx_reg + rrss_pkg::SLOT_W'(1);
        end
        if (cmd.search_init || (cmd.exec && cmd_reg == rrss_pkg::CMD_DELAY))
        begin
            base_reg <= base_slot;
            cand_reg <= ((rrss_pkg::CNT_W'(base_slot) + rrss_pkg::CNT_W'(1)) == count_reg)
                        ? '0 : base_slot + rrss_pkg::SLOT_W'(1);
            k_reg    <= rrss_pkg::CNT_W'(1);
        end
        else if (cmd.search_step && !search_exhausted && !search_hit)
        begin
            cand_reg <= cand_next;
            k_reg    <= k_reg + rrss_pkg::CNT_W'(1);
        end

        if (cmd.exec)
        begin
            case (cmd_reg)
                rrss_pkg::CMD_ADD:
                begin
                    res_sw_reg <= 1'b0;
                    if (full)
                    begin
                        res_index_reg  <= '0;
                        res_status_reg <= rrss_pkg::ST_FULL;
                    end
                    else
                    begin
                        res_index_reg  <= rrss_pkg::IDX_W'(count_reg);
                        res_status_reg <= rrss_pkg::ST_OK;
                    end
                end
                rrss_pkg::CMD_START:
                begin
                    res_index_reg <= '0;
                    if (count_reg == '0)
                    begin
                        res_sw_reg     <= 1'b0;
                        res_status_reg <= rrss_pkg::ST_IDLE;
                    end
                    else
                    begin
                        res_sw_reg     <= 1'b1;
                        res_status_reg <= rrss_pkg::ST_OK;
                    end
                end
                default:
                begin
                    // Tick and delay: on a running table the search settles the index.
                    res_index_reg <= rrss_pkg::IDX_W'(current_reg);
                    if (active)
                    begin
                        res_sw_reg     <= 1'b1;
                        res_status_reg <= rrss_pkg::ST_OK;
                    end
                    else
                    begin
                        res_sw_reg     <= 1'b0;
                        res_status_reg <= rrss_pkg::ST_IDLE;
                    end
                end
            endcase
        end
        else if (cmd.search_step)
        begin
            if (search_exhausted)
            begin
                res_index_reg <= rrss_pkg::IDX_W'(base_reg);
            end
            else if (search_hit)
            begin
                res_index_reg <= rrss_pkg::IDX_W'(cand_reg);
            end
        end

        if (cmd.load_out)
        begin
            task_index_reg     <= res_index_reg;
            switch_request_reg <= res_sw_reg;
            status_reg         <= res_status_reg;
        end
    end

    assign task_index     = task_index_reg;
    assign switch_request = switch_request_reg;
    assign status         = status_reg;

endmodule

@@ hdl/rrss_checker.sv @@
// ----------------------------------------------------------------------------
// rrss_checker
// Port-level checks of the round-robin sleep scheduler, bound to the top.
// ----------------------------------------------------------------------------
module rrss_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [rrss_pkg::IDX_W-1:0] task_index,
    input logic                       switch_request,
    input logic [1:0]                 status
);

    // A full table never requests a switch and reports slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == rrss_pkg::ST_FULL) |-> (!switch_request && task_index == '0))
    else $error("full-table result carries a switch or a slot");

    // An ignored command never requests a switch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == rrss_pkg::ST_IDLE) |-> !switch_request)
    else $error("switch requested while not running");

    // The sequencer takes one command at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer accepted while a command is in work");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(task_index)
            && $stable(switch_request) && $stable(status)))
    else $error("result changed while stalled");

endmodule

bind round_robin_sleep_scheduler_unit rrss_checker u_rrss_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .task_index     (task_index),
    .switch_request (switch_request),
    .status         (status)
);
